@@ rtl/sgbm_pkg.sv @@
package sgbm_pkg;

    localparam int MAP_BYTES_DEF = 512;
    localparam int TSN_W         = 32;
    localparam int OFS_W         = 16;
    localparam int IDX_W         = 9;
    localparam int ALU_W         = TSN_W + 1;
    localparam int IN_TDATA_W    = 112;
    localparam int OUT_TDATA_W   = 16;
    localparam logic [2:0] BIT_IN_BYTE_MAX = 3'h7;

    typedef enum logic [1:0] {
        OP_MARK  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_INC = 2'd2,
        ALU_PASS = 2'd3
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    // bits lo..hi of one bitmap byte
    function automatic logic [7:0] run_mask(input logic [2:0] lo, input logic [2:0] hi);
        run_mask = (8'hFF << lo) & (8'hFF >> (BIT_IN_BYTE_MAX - hi));
    endfunction

endpackage

@@ rtl/sgbm_alu.sv @@
module sgbm_alu (
    input  sgbm_pkg::t_alu_req             i_req,
    output logic [sgbm_pkg::ALU_W-1:0]     o_sum
);
    import sgbm_pkg::*;

    logic [ALU_W-1:0] w_b;
    logic             w_cin;

    always_comb begin
        case (i_req.op)
            ALU_ADD: begin
                w_b   = i_req.b;
                w_cin = 1'b0;
            end
            ALU_SUB: begin
                w_b   = ~i_req.b;
                w_cin = 1'b1;
            end
            ALU_INC: begin
                w_b   = '0;
                w_cin = 1'b1;
            end
            default: begin
                w_b   = '0;
                w_cin = 1'b0;
            end
        endcase
    end

    assign o_sum = i_req.a + w_b + ALU_W'(w_cin);

endmodule

@@ rtl/sack_gap_block_bitmap_marker.sv @@
// SACK gap block bitmap marker.
// Input channel s_axis carries one command item: mark a gap ack block, clear the
// whole received-TSN bitmap, or read one bitmap byte. Every item gives exactly
// one result item on m_axis, in order.
// One item is worked at a time; s_axis_tready is high only while idle. A single
// 33-bit adder under a small sequencer does all arithmetic (offset, length,
// run end, address steps). The bitmap is a single-port RAM with registered read.
// Steps from accept to result loaded:
//   mark  : offset, start, length, run end, then one read-modify-write per
//           bitmap byte touched (none if reversed or starting past the map)
//   clear : one RAM byte zeroed per cycle, over the whole map
//   read  : one RAM read of the indexed byte
//   op 3  : no work, goes straight to the result
// The next item can be accepted in the cycle after the result loads.
// Reset (i_rst_n low, synchronous) starts a clearing pass over all MAP_BYTES bytes;
// s_axis_tready stays low until it ends.
// The result sits in an output register; the next item may be accepted while it
// waits. If the receiver stalls, the next result is held in the sequencer until
// the output register empties.
module sack_gap_block_bitmap_marker #(
    parameter int MAP_BYTES = sgbm_pkg::MAP_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // op[1:0], cum_ack_tsn[33:2], map_base_tsn[65:34], gap_start[81:66],
    // gap_end[97:82], byte_index[106:98], zero[111:107]
    input  logic [sgbm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,   // last_block
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_byte[7:0], beyond_map[8], zero[15:9]
    output logic [sgbm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast    // sack_done
);
    import sgbm_pkg::*;

    localparam int AW       = $clog2(MAP_BYTES);
    localparam int BIT_W    = AW + 3;
    localparam int MAP_BITS = MAP_BYTES * 8;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_SUB  = 11'b00000000010,
        S_ADD  = 11'b00000000100,
        S_LEN  = 11'b00000001000,
        S_LAST = 11'b00000010000,
        S_RD   = 11'b00000100000,
        S_WR   = 11'b00001000000,
        S_CLR  = 11'b00010000000,
        S_GET  = 11'b00100000000,
        S_GOT  = 11'b01000000000,
        S_DONE = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // input fields
    t_op               w_op;
    logic [TSN_W-1:0]  w_cum, w_base;
    logic [OFS_W-1:0]  w_gs, w_ge;
    logic [IDX_W-1:0]  w_idx;
    logic              w_idx_ok;

    assign w_op   = t_op'(s_axis_tdata[1:0]);
    assign w_cum  = s_axis_tdata[33:2];
    assign w_base = s_axis_tdata[65:34];
    assign w_gs   = s_axis_tdata[81:66];
    assign w_ge   = s_axis_tdata[97:82];
    assign w_idx  = s_axis_tdata[106:98];
    assign w_idx_ok = 32'(w_idx) < 32'(MAP_BYTES);

    logic [TSN_W-1:0]  r_cum, r_base, r_first;
    logic [OFS_W-1:0]  r_gs, r_ge, r_len;
    logic [AW-1:0]     r_addr, r_end;
    logic [2:0]        r_lo, r_hi;
    logic              r_init, r_idx_ok;
    logic [7:0]        r_res_byte;
    logic              r_res_beyond, r_res_done;
    logic [7:0]        r_rdata;
    logic              r_ovalid;
    logic [7:0]        r_obyte;
    logic              r_obeyond, r_olast;

    logic [7:0]        r_mem [MAP_BYTES];

    t_alu_req          w_req;
    logic [ALU_W-1:0]  w_sum;

    sgbm_alu u_alu (
        .i_req (w_req),
        .o_sum (w_sum)
    );

    // shared adder operand select
    always_comb begin
        w_req.op = ALU_PASS;
        w_req.a  = '0;
        w_req.b  = '0;
        case (r_state)
            S_SUB: begin
                w_req.op = ALU_SUB;
                w_req.a  = {1'b0, r_cum};
                w_req.b  = {1'b0, r_base};
            end
            S_ADD: begin
                w_req.op = ALU_ADD;
                w_req.a  = {1'b0, r_first};
                w_req.b  = ALU_W'(r_gs);
            end
            S_LEN: begin
                w_req.op = ALU_SUB;
                w_req.a  = ALU_W'(r_ge);
                w_req.b  = ALU_W'(r_gs);
            end
            S_LAST: begin
                w_req.op = ALU_ADD;
                w_req.a  = {1'b0, r_first};
                w_req.b  = ALU_W'(r_len);
            end
            S_WR, S_CLR: begin
                w_req.op = ALU_INC;
                w_req.a  = ALU_W'(r_addr);
            end
            default: begin
                w_req.op = ALU_PASS;
            end
        endcase
    end

    logic             w_first_out, w_last_out;
    logic [BIT_W-1:0] w_stop;
    logic             w_load;
    logic             w_wr_en, w_rd_en;
    logic [7:0]       w_wr_data;

    assign w_first_out = r_first >= TSN_W'(MAP_BITS);
    assign w_last_out  = w_sum >= ALU_W'(MAP_BITS);
    assign w_stop      = w_last_out ? BIT_W'(MAP_BITS - 1) : w_sum[BIT_W-1:0];

    assign w_load  = (r_state == S_DONE) && (!r_ovalid || m_axis_tready);
    assign w_wr_en = (r_state == S_WR) || (r_state == S_CLR);
    assign w_rd_en = (r_state == S_RD) || (r_state == S_GET);
    assign w_wr_data = (r_state == S_WR)
                     ? (r_rdata | run_mask(r_lo, (r_addr == r_end) ? r_hi : BIT_IN_BYTE_MAX))
                     : 8'h00;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    case (w_op)
                        OP_MARK:  n_state = S_SUB;
                        OP_CLEAR: n_state = S_CLR;
                        OP_READ:  n_state = S_GET;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_SUB:  n_state = S_ADD;
            S_ADD:  n_state = S_LEN;
            S_LEN:  n_state = w_sum[ALU_W-1] ? S_DONE : S_LAST;
            S_LAST: n_state = w_first_out ? S_DONE : S_RD;
            S_RD:   n_state = S_WR;
            S_WR:   n_state = (r_addr == r_end) ? S_DONE : S_RD;
            S_CLR: begin
                if (r_addr == AW'(MAP_BYTES - 1)) begin
                    n_state = r_init ? S_IDLE : S_DONE;
                end
            end
            S_GET:  n_state = S_GOT;
            S_GOT:  n_state = S_DONE;
            S_DONE: n_state = w_load ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_addr   <= '0;
            r_init   <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_addr <= (w_op == OP_READ && w_idx_ok) ? AW'(w_idx) : '0;
                    end
                end
                S_LAST: begin
                    r_addr <= w_first_out ? '0 : r_first[BIT_W-1:3];
                end
                S_WR, S_CLR: begin
                    r_addr <= w_sum[AW-1:0];
                end
                default: begin
                    r_addr <= r_addr;
                end
            endcase
            if (r_state == S_CLR && r_addr == AW'(MAP_BYTES - 1)) begin
                r_init <= 1'b0;
            end
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_cum        <= w_cum;
                r_base       <= w_base;
                r_gs         <= w_gs;
                r_ge         <= w_ge;
                r_idx_ok     <= w_idx_ok;
                r_res_byte   <= 8'h00;
                r_res_beyond <= 1'b0;
                r_res_done   <= (w_op == OP_MARK) ? s_axis_tlast : 1'b0;
            end
            S_SUB: r_first <= w_sum[TSN_W-1:0];
            S_ADD: r_first <= w_sum[TSN_W-1:0];
            S_LEN: r_len   <= w_sum[OFS_W-1:0];
            S_LAST: begin
                r_res_beyond <= w_last_out;
                r_end        <= w_stop[BIT_W-1:3];
                r_hi         <= w_stop[2:0];
                r_lo         <= r_first[2:0];
            end
            S_WR: r_lo <= 3'd0;
            S_GOT: r_res_byte <= r_idx_ok ? r_rdata : 8'h00;
            default: begin
                r_lo <= r_lo;
            end
        endcase
        if (w_load) begin
            r_obyte   <= r_res_byte;
            r_obeyond <= r_res_beyond;
            r_olast   <= r_res_done;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'b0, r_obeyond, r_obyte};
    assign m_axis_tlast  = r_olast;

endmodule

@@ rtl/sgbm_checker.sv @@
module sgbm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [sgbm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                              m_axis_tlast
);
    import sgbm_pkg::*;

    // reset starts the clearing pass, so no item is taken right after it
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("item taken during clearing pass");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accept");

    // sack_done only on mark items, which never carry a read byte
    a_done_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tlast || m_axis_tdata[8]) |-> m_axis_tdata[7:0] == 8'h00)
        else $error("read byte on a mark result");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:9] == '0)
        else $error("pad bits set");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind sack_gap_block_bitmap_marker sgbm_checker u_sgbm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ tb/sv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sgbm_pkg::*;

    localparam int MAP_BYTES  = MAP_BYTES_DEF;
    localparam longint MAP_BITS = longint'(MAP_BYTES) * 8;
    localparam int RAND_ITEMS = 1700;
    localparam int HOLD_AT    = 400;     // receiver hold-off starts after this many results
    localparam int HOLD_LEN   = 300;
    localparam int CALM_LO    = 800;     // no idling on either side within this window
    localparam int CALM_HI    = 1100;
    localparam int IDLE_PCT   = 31;

    typedef struct {
        t_op         op;
        logic [31:0] cum_ack_tsn;
        logic [31:0] map_base_tsn;
        logic [15:0] gap_start;
        logic [15:0] gap_end;
        logic        last_block;
        logic [8:0]  byte_index;
    } t_gap_cmd;

    typedef struct {
        logic [7:0] read_byte;
        logic       beyond_map;
        logic       sack_done;
    } t_gap_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;   // op, cum_ack_tsn, map_base_tsn, gap_start,
                                                // gap_end, byte_index, zero pad
    logic s_axis_tlast = 1'b0;                  // last_block
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;       // read_byte, beyond_map, zero pad
    logic m_axis_tlast;                         // sack_done

    sack_gap_block_bitmap_marker #(.MAP_BYTES(MAP_BYTES)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    logic [7:0] tsn_map [MAP_BYTES];
    t_gap_cmd   pending_cmds[$];
    t_gap_res   exp_results[$];
    t_gap_cmd   cmd_on_bus;
    int         n_sent = 0;
    int         n_recv = 0;
    int         n_errors = 0;
    longint     cycle_budget = 0;
    longint     cycle_limit = 0;
    longint     cycle_cnt = 0;
    int         hold_left = 0;
    bit         hold_done = 0;

    // Updates the TSN map and returns the result the block must give.
    function automatic t_gap_res apply_gap_cmd(t_gap_cmd c);
        t_gap_res    r;
        logic [31:0] first32;
        longint      first;
        longint      last;
        longint      stop;
        longint      p;
        r = '{default: '0};
        case (c.op)
            OP_MARK: begin
                r.sack_done = c.last_block;
                if (c.gap_end >= c.gap_start) begin
                    first32 = c.cum_ack_tsn + {16'h0, c.gap_start} - c.map_base_tsn;
                    first = longint'(first32);
                    last = first + longint'(c.gap_end - c.gap_start);
                    r.beyond_map = (last >= MAP_BITS);
                    if (first < MAP_BITS) begin
                        stop = (last >= MAP_BITS) ? MAP_BITS - 1 : last;
                        for (p = first; p <= stop; p++)
                            tsn_map[p / 8][p % 8] = 1'b1;
                    end
                end
            end
            OP_CLEAR: begin
                foreach (tsn_map[i]) tsn_map[i] = 8'h00;
            end
            OP_READ: begin
                if (c.byte_index < MAP_BYTES) r.read_byte = tsn_map[c.byte_index];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_cmd(t_op op, logic [31:0] cum, logic [31:0] base, logic [15:0] gs,
                           logic [15:0] ge, logic lst, logic [8:0] idx);
        t_gap_cmd c;
        longint   nbytes;
        c = '{op: op, cum_ack_tsn: cum, map_base_tsn: base, gap_start: gs, gap_end: ge,
              last_block: lst, byte_index: idx};
        pending_cmds.push_back(c);
        // worst-case cycles for this item plus idle gaps on both sides
        case (op)
            OP_MARK: begin
                nbytes = (ge >= gs) ? longint'(ge - gs) / 8 + 2 : 0;
                if (nbytes > MAP_BYTES) nbytes = MAP_BYTES;
                cycle_budget += 6 + 2 * nbytes;
            end
            OP_CLEAR: cycle_budget += MAP_BYTES + 1;
            default:  cycle_budget += 3;
        endcase
        cycle_budget += 80;
    endtask

    task automatic add_random_cmd();
        int          sel;
        logic [31:0] cum;
        logic [15:0] gs;
        int          span;
        int          ge;
        sel = $urandom_range(99);
        cum = $urandom;
        if (sel < 55) begin
            // well-formed block landing in or near the map
            gs = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(300));
            span = ($urandom_range(19) == 0) ? $urandom_range(4200) : $urandom_range(40);
            ge = int'(gs) + span;
            if (ge > 65535) ge = 65535;
            add_cmd(OP_MARK, cum, cum + {16'h0, gs} - 32'($urandom_range(MAP_BYTES * 8 - 1)),
                    gs, 16'(ge), 1'($urandom), 9'($urandom));
        end else if (sel < 63) begin
            add_cmd(OP_MARK, cum, $urandom, 16'($urandom), 16'($urandom), 1'($urandom),
                    9'($urandom));
        end else if (sel < 68) begin
            gs = 16'($urandom_range(65535, 1));
            add_cmd(OP_MARK, cum, cum, gs, 16'($urandom_range(gs - 1)), 1'($urandom),
                    9'($urandom));
        end else if (sel < 94) begin
            add_cmd(OP_READ, cum, $urandom, 16'($urandom), 16'($urandom), 1'($urandom),
                    9'($urandom));
        end else if (sel < 96) begin
            add_cmd(OP_CLEAR, cum, $urandom, 16'($urandom), 16'($urandom), 1'($urandom),
                    9'($urandom));
        end else begin
            add_cmd(OP_NONE, cum, $urandom, 16'($urandom), 16'($urandom), 1'($urandom),
                    9'($urandom));
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        t_gap_cmd c;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                exp_results.push_back(apply_gap_cmd(cmd_on_bus));
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_cmds.size() != 0 &&
                    ((n_sent >= CALM_LO && n_sent < CALM_HI) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    c = pending_cmds.pop_front();
                    cmd_on_bus = c;
                    s_axis_tdata <= {5'b0, c.byte_index, c.gap_end, c.gap_start,
                                     c.map_base_tsn, c.cum_ack_tsn, c.op};
                    s_axis_tlast <= c.last_block;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver hold-off counter
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_recv >= HOLD_AT) begin
            // long back-pressure: sender keeps offering so the block backs up
            hold_done = 1;
            hold_left <= HOLD_LEN;
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_gap_res e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_recv++;
                if (exp_results.size() == 0) begin
                    $display("%0t: unexpected result tdata %h tlast %b", $time,
                             m_axis_tdata, m_axis_tlast);
                    n_errors++;
                end else begin
                    e = exp_results.pop_front();
                    if (m_axis_tdata[7:0] !== e.read_byte) begin
                        $display("%0t: read_byte expected %h actual %h", $time,
                                 e.read_byte, m_axis_tdata[7:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[8] !== e.beyond_map) begin
                        $display("%0t: beyond_map expected %b actual %b", $time,
                                 e.beyond_map, m_axis_tdata[8]);
                        n_errors++;
                    end
                    if (m_axis_tlast !== e.sack_done) begin
                        $display("%0t: sack_done expected %b actual %b", $time,
                                 e.sack_done, m_axis_tlast);
                        n_errors++;
                    end
                end
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
            end else if (n_recv >= CALM_LO && n_recv < CALM_HI) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= cycle_limit) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        logic [31:0] t;
        int          i;
        cycle_budget = 11 + MAP_BYTES + HOLD_LEN + 1000;
        foreach (tsn_map[k]) tsn_map[k] = 8'h00;

        t = $urandom;
        add_cmd(OP_READ, '0, '0, '0, '0, 1'b0, 9'd0);
        // offset exactly zero with all-ones TSNs
        add_cmd(OP_MARK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0, 16'd0, 1'b1, 9'd511);
        add_cmd(OP_READ, '0, '0, '0, '0, 1'b0, 9'd0);
        // single bit far past the map
        add_cmd(OP_MARK, '0, '0, 16'hFFFF, 16'hFFFF, 1'b0, 9'd0);
        // widest block: fills the map and spills past it
        add_cmd(OP_MARK, t, t, 16'd0, 16'hFFFF, 1'b1, 9'd0);
        add_cmd(OP_READ, '1, '1, '1, '1, 1'b1, 9'd511);
        add_cmd(OP_READ, '0, '0, '0, '0, 1'b0, 9'd255);
        add_cmd(OP_CLEAR, '1, '1, '1, '1, 1'b1, 9'd511);
        add_cmd(OP_READ, '0, '0, '0, '0, 1'b0, 9'd511);
        // reversed block marks nothing
        add_cmd(OP_MARK, t, t, 16'd5, 16'd4, 1'b1, 9'd0);
        add_cmd(OP_READ, '0, '0, '0, '0, 1'b0, 9'd0);
        // start behind the base wraps to a huge offset
        add_cmd(OP_MARK, t - 32'd10, t, 16'd0, 16'd20, 1'b0, 9'd0);
        add_cmd(OP_READ, '0, '0, '0, '0, 1'b0, 9'd0);
        // run across byte boundaries with partial end bytes
        add_cmd(OP_MARK, 32'd1000, 32'd1000, 16'd5, 16'd17, 1'b1, 9'd0);
        add_cmd(OP_READ, '0, '0, '0, '0, 1'b0, 9'd0);
        add_cmd(OP_READ, '0, '0, '0, '0, 1'b0, 9'd1);
        add_cmd(OP_READ, '0, '0, '0, '0, 1'b0, 9'd2);
        // ends on the last map bit, then one past it
        add_cmd(OP_MARK, t, t, 16'd4090, 16'd4095, 1'b0, 9'd0);
        add_cmd(OP_MARK, t, t + 32'd8, 16'd4090, 16'd4104, 1'b1, 9'd0);
        add_cmd(OP_READ, '0, '0, '0, '0, 1'b0, 9'd511);
        // unused op leaves the map alone
        add_cmd(OP_NONE, '1, '1, '1, '1, 1'b1, 9'd511);
        add_cmd(OP_MARK, t, t, 16'd3, 16'd3, 1'b1, 9'd0);
        add_cmd(OP_READ, '0, '0, '0, '0, 1'b0, 9'd0);
        add_cmd(OP_CLEAR, '0, '0, '0, '0, 1'b0, 9'd0);

        for (i = 0; i < RAND_ITEMS; i++) add_random_cmd();
        cycle_limit = 4 * cycle_budget;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_cmds.size() != 0 || s_axis_tvalid || exp_results.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
